// File: rtl/rcodt_pkg.sv
package rcodt_pkg;

	localparam int ENTRIES     = 16;
	localparam int COUNT_BITS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);
	localparam int CNT_EXT_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [N_W-1:0]        LAST_N   = N_W'(MAX_RESULTS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_QUERY = 2'd2,
		OP_LIST  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_RESP,
		S_LIST_RD,
		S_LIST_CHK,
		S_LIST_OUT
	} state_t;

	typedef struct packed {
		logic                  we;
		logic                  vset;
		logic                  vclr;
		logic [IDX_W-1:0]      addr;
		logic [15:0]           dev;
		logic [COUNT_BITS-1:0] refs;
		logic [1:0]            rights;
	} tbl_wr_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        major_open;
		logic [7:0]  entry_minor;
		logic [1:0]  entry_access;
		logic [15:0] open_count;
		logic        last;
	} result_t;

	function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] cnt);
		logic [CNT_EXT_W-1:0] ext;
		ext = CNT_EXT_W'(cnt);
		return (ext > CNT_EXT_W'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
	endfunction

endpackage

// File: rtl/rcodt_table.sv
module rcodt_table
	import rcodt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbl_wr_t               wr,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [ENTRIES-1:0]    valid,
	output logic [15:0]           rd_dev,
	output logic [COUNT_BITS-1:0] rd_refs,
	output logic [1:0]            rd_rights
);

	logic [ENTRIES-1:0]    valid_q;
	logic [15:0]           dev_mem    [ENTRIES];
	logic [COUNT_BITS-1:0] refs_mem   [ENTRIES];
	logic [1:0]            rights_mem [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			if (wr.vset) begin
				valid_q[wr.addr] <= 1'b1;
			end else if (wr.vclr) begin
				valid_q[wr.addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			dev_mem[wr.addr]    <= wr.dev;
			refs_mem[wr.addr]   <= wr.refs;
			rights_mem[wr.addr] <= wr.rights;
		end
		rd_dev    <= dev_mem[rd_addr];
		rd_refs   <= refs_mem[rd_addr];
		rd_rights <= rights_mem[rd_addr];
	end

	assign valid = valid_q;

endmodule

// File: rtl/rcodt_seq.sv
module rcodt_seq
	import rcodt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_op,
	input  logic [15:0]           in_dev,
	input  logic [1:0]            in_acc,
	input  logic [ENTRIES-1:0]    valid,
	input  logic [15:0]           rd_dev,
	input  logic [COUNT_BITS-1:0] rd_refs,
	input  logic [1:0]            rd_rights,
	output logic [IDX_W-1:0]      rd_addr,
	output tbl_wr_t               wr,
	input  logic                  out_free,
	output logic                  res_load,
	output result_t               res
);

	state_t state_q, state_d;

	logic [IDX_W-1:0]      idx_q, idx_s1, hit_idx_q, free_idx_q, last_idx_q, cmp_idx;
	logic                  iss_done_q, chk_s1;
	logic [1:0]            op_q, acc_q;
	logic [15:0]           dev_q;
	logic                  found_q, free_found_q, any_q;
	logic [COUNT_BITS-1:0] hit_refs_q, sum, new_refs;
	logic [1:0]            hit_rights_q;
	logic [N_W-1:0]        n_q;
	result_t               res_q, fin_res;
	logic                  ent_v, dev_hit, maj_hit, list_last;

	// Shared compare unit: one entry per cycle.
	assign cmp_idx = (state_q == S_SCAN) ? idx_s1 : idx_q;
	assign ent_v   = valid[cmp_idx];
	assign dev_hit = ent_v && (rd_dev == dev_q);
	assign maj_hit = ent_v && (rd_dev[15:8] == dev_q[15:8]);

	// Shared adder for the count update.
	assign sum = (op_q == OP_ADD) ? hit_refs_q + COUNT_BITS'(1) : hit_refs_q - COUNT_BITS'(1);

	always_comb begin
		if (op_q == OP_ADD) begin
			new_refs = (hit_refs_q == COUNT_MAX) ? hit_refs_q : sum;
		end else begin
			new_refs = (hit_refs_q == '0) ? '0 : sum;
		end
	end

	assign list_last = (idx_q == last_idx_q) || (n_q == LAST_N);

	always_comb begin
		fin_res            = '0;
		fin_res.status     = ST_OK;
		fin_res.last       = 1'b1;
		unique case (op_q)
			OP_ADD: begin
				if (!found_q && !free_found_q) begin
					fin_res.status = ST_FULL;
				end
			end
			OP_DEL: begin
				if (!found_q) begin
					fin_res.status = ST_NOTFOUND;
				end
			end
			OP_QUERY: begin
				fin_res.major_open = any_q;
			end
			default: begin
				if (!any_q) begin
					fin_res.status = ST_NOTFOUND;
				end
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_addr  = idx_q;
		res_load = 1'b0;
		res      = res_q;
		wr       = '0;
		wr.dev   = dev_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (chk_s1 && idx_s1 == LAST_IDX) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (op_q == OP_ADD) begin
					if (found_q) begin
						wr.we     = 1'b1;
						wr.addr   = hit_idx_q;
						wr.refs   = new_refs;
						wr.rights = hit_rights_q | acc_q;
					end else if (free_found_q) begin
						wr.we     = 1'b1;
						wr.vset   = 1'b1;
						wr.addr   = free_idx_q;
						wr.refs   = COUNT_BITS'(1);
						wr.rights = acc_q;
					end
				end else if (op_q == OP_DEL && found_q) begin
					wr.we     = 1'b1;
					wr.vclr   = (new_refs == '0);
					wr.addr   = hit_idx_q;
					wr.refs   = new_refs;
					wr.rights = hit_rights_q;
				end
				state_d = (op_q == OP_LIST && any_q) ? S_LIST_RD : S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LIST_RD: begin
				state_d = S_LIST_CHK;
			end
			S_LIST_CHK: begin
				state_d = maj_hit ? S_LIST_OUT : S_LIST_RD;
			end
			S_LIST_OUT: begin
				res              = '0;
				res.status       = ST_OK;
				res.entry_minor  = rd_dev[7:0];
				res.entry_access = rd_rights;
				res.open_count   = sat16(rd_refs);
				res.last         = list_last;
				if (out_free) begin
					res_load = 1'b1;
					state_d  = list_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			idx_s1       <= '0;
			iss_done_q   <= 1'b0;
			chk_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			any_q        <= 1'b0;
			n_q          <= '0;
		end else begin
			chk_s1 <= (state_q == S_SCAN) && !iss_done_q;
			idx_s1 <= idx_q;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q        <= '0;
						iss_done_q   <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						any_q        <= 1'b0;
						n_q          <= '0;
					end
				end
				S_SCAN: begin
					if (!iss_done_q) begin
						if (idx_q == LAST_IDX) begin
							iss_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					if (chk_s1) begin
						if (dev_hit && !found_q) begin
							found_q <= 1'b1;
						end
						if (!ent_v && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (maj_hit) begin
							any_q <= 1'b1;
						end
					end
				end
				S_FINISH: begin
					idx_q <= '0;
					n_q   <= '0;
				end
				S_LIST_CHK: begin
					if (!maj_hit) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_LIST_OUT: begin
					if (out_free && !list_last) begin
						idx_q <= idx_q + IDX_W'(1);
						n_q   <= n_q + N_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q  <= in_op;
			dev_q <= in_dev;
			acc_q <= in_acc;
		end
		if (state_q == S_SCAN && chk_s1) begin
			if (dev_hit && !found_q) begin
				hit_idx_q    <= idx_s1;
				hit_refs_q   <= rd_refs;
				hit_rights_q <= rd_rights;
			end
			if (!ent_v && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (maj_hit) begin
				last_idx_q <= idx_s1;
			end
		end
		if (state_q == S_FINISH) begin
			res_q <= fin_res;
		end
	end

`ifndef SYNTH
	a_wr_only_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> state_q == S_FINISH)
		else $error("table written outside the finish step");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded into a busy output register");

	a_list_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST_OUT |-> valid[idx_q])
		else $error("listed entry is not valid");

	a_set_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.vset && wr.vclr))
		else $error("valid bit set and cleared together");
`endif

endmodule

// File: rtl/refcounted_open_device_table_unit.sv
// Channel   Direction  tdata                                       tuser  tlast
// s_axis    in         op, dev, access_mask (24 bits)              -      -
// m_axis    out        status, major_open, entry_minor,            -      last
//                      entry_access, open_count (32 bits)
// Each transaction scans all 16 entries through one compare unit, one entry per cycle
// behind a registered table read, whether it is an add, delete, query or list.
// A reopen list adds a second pass that reads and checks each entry up to the last match.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled m_axis holds the sequencer; s_axis is taken only when the sequencer is idle.
module refcounted_open_device_table_unit
	import rcodt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // op[1:0], dev[17:2], access_mask[19:18], zero[23:20]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // status[1:0], major_open[2], entry_minor[10:3],
	                                   // entry_access[12:11], open_count[28:13], zero[31:29]
	output logic        m_axis_tlast
);

	tbl_wr_t               wr;
	logic [IDX_W-1:0]      rd_addr;
	logic [ENTRIES-1:0]    valid;
	logic [15:0]           rd_dev;
	logic [COUNT_BITS-1:0] rd_refs;
	logic [1:0]            rd_rights;
	logic                  out_free, res_load;
	result_t               res, out_q;
	logic                  out_valid_q;

	assign out_free = !out_valid_q || m_axis_tready;

	rcodt_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.valid     (valid),
		.rd_dev    (rd_dev),
		.rd_refs   (rd_refs),
		.rd_rights (rd_rights)
	);

	rcodt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tdata[1:0]),
		.in_dev    (s_axis_tdata[17:2]),
		.in_acc    (s_axis_tdata[19:18]),
		.valid     (valid),
		.rd_dev    (rd_dev),
		.rd_refs   (rd_refs),
		.rd_rights (rd_rights),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.open_count, out_q.entry_access, out_q.entry_minor,
		out_q.major_open, out_q.status};
	assign m_axis_tlast  = out_q.last;

endmodule

// File: verif/tb_refcounted_open_device_table_unit.sv
module tb_refcounted_open_device_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rcodt_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int BURST_ADDS = 8;
	localparam int RANDOM_REQUESTS = 170;

	typedef struct packed {
		op_t         op;
		logic [15:0] dev;
		logic [1:0]  access;
		logic        hurry;
	} dev_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic                  tbl_valid  [ENTRIES];
	logic [15:0]           tbl_dev    [ENTRIES];
	logic [COUNT_BITS-1:0] tbl_refs   [ENTRIES];
	logic [1:0]            tbl_rights [ENTRIES];

	dev_request_t pending_requests[$];
	dev_request_t cur_request;
	result_t      expected_results[$];
	logic [15:0]  live_devs[$];

	int gap_left = 0;
	int stall_left = 0;
	bit calm = 1'b0;
	bit fast_lane = 1'b0;
	int idle_cycles = 0;
	int mismatch_count = 0;
	int requests_done = 0;
	int results_seen = 0;
	int full_answers = 0;
	int listed_entries = 0;

	refcounted_open_device_table_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_major();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h42;
			3: return 8'hA5;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_dev();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6 && live_devs.size() > 0) return live_devs[$urandom_range(0, live_devs.size() - 1)];
		if (r < 9) return {pick_major(), ($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom))};
		return 16'($urandom);
	endfunction

	task automatic queue_request(input op_t op, input logic [15:0] dev, input logic [1:0] access,
			input bit hurry = 1'b0);
		dev_request_t rq;
		int hit;
		rq.op = op;
		rq.dev = dev;
		rq.access = access;
		rq.hurry = hurry;
		pending_requests.push_back(rq);
		if (!hurry) begin
			if (op == OP_ADD) begin
				live_devs.push_back(dev);
			end else if (op == OP_DEL) begin
				hit = -1;
				foreach (live_devs[i]) if (hit < 0 && live_devs[i] == dev) hit = i;
				if (hit >= 0) live_devs.delete(hit);
			end
		end
	endtask

	// Minors step by an odd stride, so all of them differ.
	task automatic fill_major(input logic [7:0] major, input int count);
		logic [7:0] base;
		logic [7:0] stride;
		base = 8'($urandom);
		stride = 8'(2 * $urandom_range(0, 127) + 1);
		for (int k = 0; k < count; k++)
			queue_request(OP_ADD, {major, 8'(base + k * stride)}, 2'($urandom_range(0, 3)));
		queue_request(OP_LIST, {major, 8'($urandom)}, 2'd0);
	endtask

	task automatic drain_table();
		while (live_devs.size() > 0) queue_request(OP_DEL, live_devs[0], 2'($urandom_range(0, 3)));
	endtask

	task automatic update_table(input dev_request_t rq);
		int hit;
		int slot;
		int n;
		result_t r;
		result_t held;
		logic [63:0] cnt;
		r = '0;
		r.last = 1'b1;
		held = '0;
		hit = -1;
		slot = -1;
		n = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && tbl_valid[i] && tbl_dev[i] == rq.dev) hit = i;
			if (slot < 0 && !tbl_valid[i]) slot = i;
		end
		case (rq.op)
			OP_ADD: begin
				if (hit >= 0) begin
					if (tbl_refs[hit] != COUNT_MAX) tbl_refs[hit] = tbl_refs[hit] + 1'b1;
					tbl_rights[hit] = tbl_rights[hit] | rq.access;
				end else if (slot >= 0) begin
					tbl_valid[slot] = 1'b1;
					tbl_dev[slot] = rq.dev;
					tbl_refs[slot] = COUNT_BITS'(1);
					tbl_rights[slot] = rq.access;
				end else begin
					r.status = ST_FULL;
					full_answers++;
				end
				expected_results.push_back(r);
			end
			OP_DEL: begin
				if (hit < 0) begin
					r.status = ST_NOTFOUND;
				end else begin
					tbl_refs[hit] = tbl_refs[hit] - 1'b1;
					if (tbl_refs[hit] == '0) tbl_valid[hit] = 1'b0;
				end
				expected_results.push_back(r);
			end
			OP_QUERY: begin
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_dev[i][15:8] == rq.dev[15:8]) r.major_open = 1'b1;
				expected_results.push_back(r);
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i] && tbl_dev[i][15:8] == rq.dev[15:8] && n < MAX_RESULTS) begin
						if (n > 0) expected_results.push_back(held);
						cnt = 64'(tbl_refs[i]);
						held = '0;
						held.status = ST_OK;
						held.entry_minor = tbl_dev[i][7:0];
						held.entry_access = tbl_rights[i];
						held.open_count = (cnt > 64'hFFFF) ? 16'hFFFF : cnt[15:0];
						n++;
					end
				end
				if (n == 0) begin
					r.status = ST_NOTFOUND;
					expected_results.push_back(r);
				end else begin
					held.last = 1'b1;
					expected_results.push_back(held);
					listed_entries += n;
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : request_driver
		bit slot_free;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_left <= 0;
		end else begin
			slot_free = !s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				update_table(cur_request);
				requests_done++;
				slot_free = 1'b1;
				if ($urandom_range(0, 24) == 0) calm <= !calm;
			end
			if (slot_free) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_request = pending_requests.pop_front();
					s_axis_tdata <= {4'b0, cur_request.access, cur_request.dev, cur_request.op};
					s_axis_tvalid <= 1'b1;
					fast_lane <= cur_request.hurry;
					gap_left <= cur_request.hurry ? 0 : pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
						$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
					check_field("major_open", 32'(want.major_open), 32'(m_axis_tdata[2]));
					check_field("entry_minor", 32'(want.entry_minor), 32'(m_axis_tdata[10:3]));
					check_field("entry_access", 32'(want.entry_access),
						32'(m_axis_tdata[12:11]));
					check_field("open_count", 32'(want.open_count), 32'(m_axis_tdata[28:13]));
					check_field("last", 32'(want.last), 32'(m_axis_tlast));
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!fast_lane && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, expected_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int target;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_dev[i] = '0;
			tbl_refs[i] = '0;
			tbl_rights[i] = '0;
		end

		// Empty table, device zero as an ordinary id, access merging and major lookups.
		queue_request(OP_QUERY, 16'h0000, 2'd0);
		queue_request(OP_LIST, 16'h0000, 2'd0);
		queue_request(OP_DEL, 16'h0000, 2'd3);
		queue_request(OP_ADD, 16'h0000, 2'd1);
		queue_request(OP_ADD, 16'h0000, 2'd2);
		queue_request(OP_ADD, 16'hFFFF, 2'd3);
		queue_request(OP_ADD, 16'hFF00, 2'd0);
		queue_request(OP_ADD, 16'h00FF, 2'd2);
		queue_request(OP_QUERY, 16'hFF5A, 2'd0);
		queue_request(OP_QUERY, 16'h7E00, 2'd0);
		queue_request(OP_LIST, 16'hFF00, 2'd0);
		queue_request(OP_LIST, 16'h0000, 2'd0);
		queue_request(OP_DEL, 16'h0000, 2'd0);
		queue_request(OP_DEL, 16'h0000, 2'd0);
		queue_request(OP_QUERY, 16'h0000, 2'd0);
		queue_request(OP_LIST, 16'h00FF, 2'd0);
		drain_table();

		// One more add than there are entries, so the table reports full.
		target = pending_requests.size() + RANDOM_REQUESTS;
		fill_major(pick_major(), ENTRIES + 1);
		queue_request(OP_ADD, live_devs[0], 2'($urandom_range(0, 3)));
		drain_table();
		while (pending_requests.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: queue_request(OP_ADD, pick_dev(), 2'($urandom_range(0, 3)));
				4, 5: queue_request(OP_DEL, pick_dev(), 2'($urandom_range(0, 3)));
				6: queue_request(OP_QUERY, pick_dev(), 2'($urandom_range(0, 3)));
				7: queue_request(OP_LIST, pick_dev(), 2'($urandom_range(0, 3)));
				8: fill_major(pick_major(), $urandom_range(3, ENTRIES + 2));
				default: drain_table();
			endcase
		end
		drain_table();

		// Back-to-back adds on one device with no gaps or stalls, then step it down and up.
		for (int k = 0; k < BURST_ADDS; k++) queue_request(OP_ADD, 16'h5AC3, 2'(k), 1'b1);
		queue_request(OP_LIST, 16'h5A00, 2'd0);
		queue_request(OP_DEL, 16'h5AC3, 2'd0);
		queue_request(OP_LIST, 16'h5A11, 2'd0);
		queue_request(OP_ADD, 16'h5AC3, 2'd0);
		queue_request(OP_ADD, 16'h5AC3, 2'd0);
		queue_request(OP_LIST, 16'h5AFF, 2'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Checked %0d requests and %0d results: %0d listed entries, %0d full-table answers.",
			requests_done, results_seen, listed_entries, full_answers);
		$display("One device was opened %0d times back to back with the result side never stalled.",
			BURST_ADDS);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: refcounted_open_device_table_unit.f
rtl/rcodt_pkg.sv
rtl/rcodt_table.sv
rtl/rcodt_seq.sv
rtl/refcounted_open_device_table_unit.sv
verif/tb_refcounted_open_device_table_unit.sv
